FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file cmm_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define CMM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define CMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cmm_pkg.sv
// ----------------------------------------------------------------------------
// cmm_pkg: shared types and constants
// Sizes, codes, handshake structs and helper functions of the confusion
// matrix metrics block.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_CLASSES = 16;
  localparam int COUNT_WIDTH = 32;
  localparam int CLS_W       = $clog2(MAX_CLASSES);
  localparam int ADDR_W      = 2 * CLS_W;
  localparam int DEPTH       = 2 ** ADDR_W;
  localparam int LBL_W       = 4;
  localparam int CFG_W       = 5;
  localparam int Q_W         = 17;
  localparam int Q_ONE       = 65536;
  localparam int FRAC_W      = 16;
  // quotient bits produced per division; every ratio here stays below 2^QB
  localparam int QB          = 18;
  localparam int DEN_W       = (COUNT_WIDTH > QB) ? COUNT_WIDTH : QB;
  localparam int DIV_W       = (COUNT_WIDTH + FRAC_W > 35) ? COUNT_WIDTH + FRAC_W : 35;
  localparam int OUT_W       = 32;
  localparam int EXT_W       = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
  localparam int CLASSES_RST = 16;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [Q_W-1:0]         q16_t;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CELL   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [DEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    q16_t quotient;
  } div_rsp_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic logic [OUT_W-1:0] out32(count_t v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > EXT_W'(32'hFFFF_FFFF)) return 32'hFFFF_FFFF;
    return e[OUT_W-1:0];
  endfunction

  function automatic logic label_ok(logic [LBL_W-1:0] label, logic [CFG_W-1:0] limit);
    return (CFG_W'(label) < limit) && (int'(label) < MAX_CLASSES);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [LBL_W-1:0] row,
                                                  logic [LBL_W-1:0] col);
    return {CLS_W'(row), CLS_W'(col)};
  endfunction

endpackage

FILE: hdl/cmm_if.sv
// ----------------------------------------------------------------------------
// cmm_in_if / cmm_out_if: valid-ready channels
// Request channel and result channel of the confusion matrix metrics block.
// ----------------------------------------------------------------------------
interface cmm_in_if;
  logic                           valid;
  logic                           ready;
  cmm_pkg::mode_e                 mode;
  logic [cmm_pkg::LBL_W-1:0]      actual_class;
  logic [cmm_pkg::LBL_W-1:0]      predicted_class;
  logic [cmm_pkg::LBL_W-1:0]      query_class;

  modport source(output valid, mode, actual_class, predicted_class, query_class,
                 input ready);
  modport sink(input valid, mode, actual_class, predicted_class, query_class,
               output ready);
endinterface

interface cmm_out_if;
  logic                       valid;
  logic                       ready;
  cmm_pkg::q16_t              precision_q16;
  cmm_pkg::q16_t              recall_q16;
  cmm_pkg::q16_t              f1_q16;
  cmm_pkg::q16_t              accuracy_q16;
  logic [cmm_pkg::OUT_W-1:0]  cell_count;
  logic [cmm_pkg::OUT_W-1:0]  sample_count;
  logic                       bad_label_seen;

  modport source(output valid, precision_q16, recall_q16, f1_q16, accuracy_q16,
                 cell_count, sample_count, bad_label_seen, input ready);
  modport sink(input valid, precision_q16, recall_q16, f1_q16, accuracy_q16,
               cell_count, sample_count, bad_label_seen, output ready);
endinterface

FILE: hdl/cmm_divider.sv
// ----------------------------------------------------------------------------
// cmm_divider: shared radix-2 restoring divider
// Produces an QB-bit quotient one bit per cycle and clamps it to 1.0 in Q1.16.
// ----------------------------------------------------------------------------
module cmm_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmm_pkg::div_req_t req_i,
  output cmm_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(cmm_pkg::QB + 1);

  logic [cmm_pkg::DEN_W-1:0] rem_q;
  logic [cmm_pkg::DEN_W-1:0] den_q;
  logic [cmm_pkg::QB-1:0]    low_q;
  logic [cmm_pkg::QB-1:0]    quo_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      done_q;
  logic [cmm_pkg::DEN_W:0]   trial;
  logic                      fits;

  // trial subtract of the shifted remainder
  assign trial = {rem_q, low_q[cmm_pkg::QB-1]};
  assign fits  = trial >= {1'b0, den_q};

  // load on start, then retire one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q <= CNT_W'(cmm_pkg::QB);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= cmm_pkg::DEN_W'(req_i.dividend[cmm_pkg::DIV_W-1:cmm_pkg::QB]);
      low_q <= req_i.dividend[cmm_pkg::QB-1:0];
      den_q <= req_i.divisor;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? cmm_pkg::DEN_W'(trial - {1'b0, den_q}) : trial[cmm_pkg::DEN_W-1:0];
      low_q <= {low_q[cmm_pkg::QB-2:0], 1'b0};
      quo_q <= {quo_q[cmm_pkg::QB-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = (quo_q > cmm_pkg::QB'(cmm_pkg::Q_ONE)) ?
                          cmm_pkg::Q_W'(cmm_pkg::Q_ONE) : quo_q[cmm_pkg::Q_W-1:0];

endmodule

FILE: hdl/cmm_count_store.sv
// ----------------------------------------------------------------------------
// cmm_count_store: confusion matrix count memory
// One write and one registered read port; per-entry valid bits make every
// entry read as zero after reset until it is first written.
// ----------------------------------------------------------------------------
module cmm_count_store (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [cmm_pkg::ADDR_W-1:0]   rd_addr_i,
  output cmm_pkg::count_t              rd_data_o,
  input  logic                         wr_en_i,
  input  logic [cmm_pkg::ADDR_W-1:0]   wr_addr_i,
  input  cmm_pkg::count_t              wr_data_i
);

  cmm_pkg::count_t            mem_q [cmm_pkg::DEPTH];
  logic [cmm_pkg::DEPTH-1:0]  valid_q;
  cmm_pkg::count_t            rd_data_q;
  logic                       rd_valid_q;

  // mark written entries, register the valid bit of the read entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) valid_q[wr_addr_i] <= 1'b1;
      if (rd_en_i) rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  // memory array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: hdl/confusion_matrix_metrics.sv
// ----------------------------------------------------------------------------
// confusion_matrix_metrics: confusion matrix with precision, recall, F1
// Records label pairs and reports per-class metrics, accuracy or one cell.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is high only while the sequencer is
// idle, and a finished result waits in the output register without blocking
// the next request. A record reads its cell on transfer and writes it back
// in S_REC_WR, a cell read goes through S_CELL to S_OUT, and a query runs
// up to 4 divisions (precision, recall, F1, accuracy) on the single shared
// 18-step divider. A result that is ready while the previous one is
// still waiting in the output register holds the sequencer in its last
// state until that transfer. The count matrix reads as zero after reset
// through per-entry valid bits, so no clearing pass is needed and a request
// may follow reset at once.
module confusion_matrix_metrics (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cmm_pkg::CFG_W-1:0]     cfg_wdata_i,
  cmm_in_if.sink                        in_i,
  cmm_out_if.source                     out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_REC_WR, S_CELL, S_P_GO, S_P_WAIT, S_R_GO, S_R_WAIT,
    S_MUL, S_F_GO, S_F_WAIT, S_A_GO, S_A_WAIT, S_OUT
  } state_e;

  state_e                       state_q;
  logic [cmm_pkg::CFG_W-1:0]    limit_q;
  logic [cmm_pkg::LBL_W-1:0]    act_q, pred_q, cls_q;
  cmm_pkg::count_t              row_tot_q [cmm_pkg::MAX_CLASSES];
  cmm_pkg::count_t              col_tot_q [cmm_pkg::MAX_CLASSES];
  cmm_pkg::count_t              correct_q, sample_q, tp_q;
  logic                         bad_q;
  cmm_pkg::q16_t                prec_q, rec_q, f1_q, acc_q;
  logic [cmm_pkg::OUT_W-1:0]    cell_q;
  logic [cmm_pkg::DIV_W-1:0]    prod_q;
  logic [cmm_pkg::DEN_W-1:0]    sum_q;
  logic                         out_vld_q;
  cmm_pkg::q16_t                res_prec_q, res_rec_q, res_f1_q, res_acc_q;
  logic [cmm_pkg::OUT_W-1:0]    res_cell_q, res_samp_q;
  logic                         res_bad_q;

  logic                         in_acc;
  logic                         act_ok, pred_ok, cls_ok;
  logic [cmm_pkg::CLS_W-1:0]    cls_idx, act_idx, pred_idx;
  cmm_pkg::count_t              rd_data;
  logic                         mem_we;
  cmm_pkg::div_req_t            div_req;
  cmm_pkg::div_rsp_t            div_rsp;
  logic                         out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign act_ok     = cmm_pkg::label_ok(in_i.actual_class, limit_q);
  assign pred_ok    = cmm_pkg::label_ok(in_i.predicted_class, limit_q);
  assign cls_ok     = cmm_pkg::label_ok(in_i.query_class, limit_q);
  assign cls_idx    = cmm_pkg::CLS_W'(cls_q);
  assign act_idx    = cmm_pkg::CLS_W'(act_q);
  assign pred_idx   = cmm_pkg::CLS_W'(pred_q);
  assign mem_we     = (state_q == S_REC_WR);
  assign out_free   = !out_vld_q || out_o.ready;

  // count memory: read issued on transfer, written back on record
  cmm_count_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i ((in_i.mode == cmm_pkg::MODE_QUERY) ?
                cmm_pkg::cell_addr(in_i.query_class, in_i.query_class) :
                cmm_pkg::cell_addr(in_i.actual_class, in_i.predicted_class)),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_we),
    .wr_addr_i (cmm_pkg::cell_addr(act_q, pred_q)),
    .wr_data_i (cmm_pkg::sat_inc(rd_data))
  );

  // feed the shared divider from the sequencer state
  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_P_GO: begin
        div_req.start    = (col_tot_q[cls_idx] != '0);
        div_req.dividend = cmm_pkg::DIV_W'({rd_data, 16'h0});
        div_req.divisor  = cmm_pkg::DEN_W'(col_tot_q[cls_idx]);
      end
      S_R_GO: begin
        div_req.start    = (row_tot_q[cls_idx] != '0);
        div_req.dividend = cmm_pkg::DIV_W'({tp_q, 16'h0});
        div_req.divisor  = cmm_pkg::DEN_W'(row_tot_q[cls_idx]);
      end
      S_F_GO: begin
        div_req.start    = (sum_q != '0);
        div_req.dividend = prod_q;
        div_req.divisor  = sum_q;
      end
      S_A_GO: begin
        div_req.start    = (sample_q != '0);
        div_req.dividend = cmm_pkg::DIV_W'({correct_q, 16'h0});
        div_req.divisor  = cmm_pkg::DEN_W'(sample_q);
      end
      default: div_req = '0;
    endcase
  end

  cmm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // raise the result flag on load, drop it on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == S_OUT) && out_free) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // sequencer, totals and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      limit_q   <= cmm_pkg::CFG_W'(cmm_pkg::CLASSES_RST);
      row_tot_q <= '{default: '0};
      col_tot_q <= '{default: '0};
      correct_q <= '0;
      sample_q  <= '0;
      bad_q     <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_wdata_i;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            act_q  <= in_i.actual_class;
            pred_q <= in_i.predicted_class;
            cls_q  <= in_i.query_class;
            prec_q <= '0;
            rec_q  <= '0;
            f1_q   <= '0;
            acc_q  <= '0;
            cell_q <= '0;
            unique case (in_i.mode)
              cmm_pkg::MODE_RECORD: begin
                if (act_ok && pred_ok) state_q <= S_REC_WR;
                else bad_q <= 1'b1;
              end
              cmm_pkg::MODE_QUERY: begin
                if (cls_ok) begin
                  state_q <= S_P_GO;
                end else begin
                  bad_q   <= 1'b1;
                  state_q <= S_A_GO;
                end
              end
              cmm_pkg::MODE_CELL: begin
                if (act_ok && pred_ok) begin
                  state_q <= S_CELL;
                end else begin
                  bad_q   <= 1'b1;
                  state_q <= S_OUT;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_REC_WR: begin
          row_tot_q[act_idx]  <= cmm_pkg::sat_inc(row_tot_q[act_idx]);
          col_tot_q[pred_idx] <= cmm_pkg::sat_inc(col_tot_q[pred_idx]);
          if (act_q == pred_q) correct_q <= cmm_pkg::sat_inc(correct_q);
          sample_q <= cmm_pkg::sat_inc(sample_q);
          state_q  <= S_IDLE;
        end
        S_CELL: begin
          cell_q  <= cmm_pkg::out32(rd_data);
          state_q <= S_OUT;
        end
        S_P_GO: begin
          tp_q    <= rd_data;
          state_q <= div_req.start ? S_P_WAIT : S_R_GO;
        end
        S_P_WAIT: begin
          if (div_rsp.done) begin
            prec_q  <= div_rsp.quotient;
            state_q <= S_R_GO;
          end
        end
        S_R_GO: state_q <= div_req.start ? S_R_WAIT : S_MUL;
        S_R_WAIT: begin
          if (div_rsp.done) begin
            rec_q   <= div_rsp.quotient;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= cmm_pkg::DIV_W'({34'(prec_q) * 34'(rec_q), 1'b0});
          sum_q   <= cmm_pkg::DEN_W'(18'(prec_q) + 18'(rec_q));
          state_q <= S_F_GO;
        end
        S_F_GO: state_q <= div_req.start ? S_F_WAIT : S_A_GO;
        S_F_WAIT: begin
          if (div_rsp.done) begin
            f1_q    <= div_rsp.quotient;
            state_q <= S_A_GO;
          end
        end
        S_A_GO: state_q <= div_req.start ? S_A_WAIT : S_OUT;
        S_A_WAIT: begin
          if (div_rsp.done) begin
            acc_q   <= div_rsp.quotient;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_prec_q <= prec_q;
            res_rec_q  <= rec_q;
            res_f1_q   <= f1_q;
            res_acc_q  <= acc_q;
            res_cell_q <= cell_q;
            res_samp_q <= cmm_pkg::out32(sample_q);
            res_bad_q  <= bad_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.precision_q16  = res_prec_q;
  assign out_o.recall_q16     = res_rec_q;
  assign out_o.f1_q16         = res_f1_q;
  assign out_o.accuracy_q16   = res_acc_q;
  assign out_o.cell_count     = res_cell_q;
  assign out_o.sample_count   = res_samp_q;
  assign out_o.bad_label_seen = res_bad_q;

endmodule

FILE: hdl/cmm_checker.sv
// ----------------------------------------------------------------------------
// cmm_checker: port-level checks of the confusion matrix metrics block
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input cmm_pkg::mode_e             in_mode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input cmm_pkg::q16_t              precision_i,
  input cmm_pkg::q16_t              recall_i,
  input cmm_pkg::q16_t              f1_i,
  input cmm_pkg::q16_t              accuracy_i,
  input logic [cmm_pkg::OUT_W-1:0]  cell_count_i,
  input logic                       bad_label_i
);

  logic query_acc;
  logic ratios_ok;
  logic metrics_zero;

  assign query_acc    = in_valid_i && in_ready_i && (in_mode_i == cmm_pkg::MODE_QUERY);
  assign ratios_ok    = (precision_i <= cmm_pkg::Q_W'(cmm_pkg::Q_ONE)) &&
                        (recall_i <= cmm_pkg::Q_W'(cmm_pkg::Q_ONE)) &&
                        (f1_i <= cmm_pkg::Q_W'(cmm_pkg::Q_ONE)) &&
                        (accuracy_i <= cmm_pkg::Q_W'(cmm_pkg::Q_ONE));
  assign metrics_zero = (precision_i == '0) && (recall_i == '0) &&
                        (f1_i == '0) && (accuracy_i == '0);

  // hold a stalled result
  `CMM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(cell_count_i), "result dropped while stalled")

  // go busy after a query transfer
  `CMM_ASSERT_NEXT(a_one_at_a_time, query_acc, !in_ready_i, "request taken while busy")

  // keep every ratio at or below one
  `CMM_ASSERT_NOW(a_ratio_range, out_valid_i, ratios_ok, "ratio above one")

  // a cell result carries no metrics
  `CMM_ASSERT_NOW(a_cell_no_metrics, out_valid_i && (cell_count_i != '0), metrics_zero, "metrics on cell result")

  // keep the bad-label flag sticky across transfers
  `CMM_ASSERT_NEXT(a_bad_sticky, out_valid_i && out_ready_i && bad_label_i, !out_valid_i || bad_label_i, "bad-label flag cleared")

endmodule

bind confusion_matrix_metrics cmm_checker u_cmm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_mode_i    (in_i.mode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .precision_i  (out_o.precision_q16),
  .recall_i     (out_o.recall_q16),
  .f1_i         (out_o.f1_q16),
  .accuracy_i   (out_o.accuracy_q16),
  .cell_count_i (out_o.cell_count),
  .bad_label_i  (out_o.bad_label_seen)
);
